// ===== hdl/t1ex_pkg.sv =====
package t1ex_pkg;

  // Number of prefix key bytes that encrypt mode sends ahead of the data.
  localparam int unsigned PREFIX_BYTES = 4;
  // Step counter: counts prefix bytes, 0 .. PREFIX_BYTES.
  localparam int unsigned STEP_W = (PREFIX_BYTES > 0) ? $clog2(PREFIX_BYTES + 1) : 1;
  // Byte select within prefix_key.
  localparam int unsigned PSEL_W = 2;

  localparam logic [15:0] KEY_MUL    = 16'd52845;
  localparam logic [15:0] KEY_ADD    = 16'd22719;
  // eexec seed; charstrings use 4330, written through the seed register.
  localparam logic [15:0] SEED_EEXEC = 16'd55665;
  localparam logic [2:0]  DISCARD_RESET = 3'd4;

  // Both queues are two entries deep.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_DECRYPT_MODE  = 2'd0,
    REG_SEED_VALUE    = 2'd1,
    REG_PREFIX_KEY    = 2'd2,
    REG_DISCARD_COUNT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic        decrypt_mode;
    logic [15:0] seed_value;
    logic [31:0] prefix_key;
    logic [2:0]  discard_count;
  } cfg_t;

  // Command passed from the front end to the key engine.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
    logic       decrypt;
  } cmd_t;

  // Key update: (key + cipher byte) * 52845 + 22719, mod 2^16.
  function automatic logic [15:0] next_key(input logic [15:0] key, input logic [7:0] c);
    logic [15:0] sum;
    logic [31:0] prod;
    sum  = key + {8'd0, c};
    prod = sum * KEY_MUL;
    return prod[15:0] + KEY_ADD;
  endfunction

endpackage

// ===== hdl/t1ex_cfg.sv =====
module t1ex_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [t1ex_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [t1ex_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [t1ex_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output t1ex_pkg::cfg_t                     cfg_o
);
  import t1ex_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_DECRYPT_MODE:  cfg_d.decrypt_mode  = pwdata[0];
        REG_SEED_VALUE:    cfg_d.seed_value    = pwdata[15:0];
        REG_PREFIX_KEY:    cfg_d.prefix_key    = pwdata[31:0];
        REG_DISCARD_COUNT: cfg_d.discard_count = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DECRYPT_MODE:  prdata = {31'd0, cfg_q.decrypt_mode};
      REG_SEED_VALUE:    prdata = {16'd0, cfg_q.seed_value};
      REG_PREFIX_KEY:    prdata = cfg_q.prefix_key;
      REG_DISCARD_COUNT: prdata = {29'd0, cfg_q.discard_count};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decrypt_mode  <= 1'b1;
      cfg_q.seed_value    <= SEED_EEXEC;
      cfg_q.prefix_key    <= '0;
      cfg_q.discard_count <= DISCARD_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/t1ex_front.sv =====
module t1ex_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  t1ex_pkg::item_t item_i,
  input  logic            push_i,
  output logic            full_o,
  input  logic            decrypt_i,
  output t1ex_pkg::cmd_t  cmd_o,
  output logic            cmd_valid_o,
  input  logic            cmd_pop_i
);
  import t1ex_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;
  cmd_t              cmd_new;

  assign full_o      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // Tag each item with the mode it is to be run in.
  assign cmd_new.data_byte    = item_i.data_byte;
  assign cmd_new.stream_start = item_i.stream_start;
  assign cmd_new.decrypt      = decrypt_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  assign cmd_o = mem_q[rd_ptr_q];

endmodule

// ===== hdl/t1ex_back.sv =====
module t1ex_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  t1ex_pkg::cfg_t    cfg_i,
  input  t1ex_pkg::cmd_t    cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  output t1ex_pkg::result_t res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i
);
  import t1ex_pkg::*;

  logic [15:0]       key_q, key_d, key_eff;
  logic [2:0]        skip_q, skip_d, skip_eff;
  logic              pend_q, pend_d, pend_eff;
  logic [STEP_W-1:0] step_q, step_d;
  logic              load;
  logic              in_prefix;
  logic [PSEL_W-1:0] byte_sel;
  logic [7:0]        src_byte, xor_byte, ciph_byte;
  logic              emit, advance;

  // Stream start reloads the key and counters, but only on the first step.
  assign load     = cmd_i.stream_start && (step_q == '0);
  assign key_eff  = load ? cfg_i.seed_value    : key_q;
  assign skip_eff = load ? cfg_i.discard_count : skip_q;
  assign pend_eff = load ? 1'b1                : pend_q;

  assign in_prefix = !cmd_i.decrypt && pend_eff && (step_q < STEP_W'(PREFIX_BYTES));
  assign byte_sel  = PSEL_W'(PREFIX_BYTES - 1) - PSEL_W'(step_q);
  assign src_byte  = in_prefix ? cfg_i.prefix_key[8*byte_sel +: 8] : cmd_i.data_byte;
  assign xor_byte  = key_eff[15:8] ^ src_byte;
  assign ciph_byte = cmd_i.decrypt ? src_byte : xor_byte;

  assign emit    = cmd_valid_i && !(cmd_i.decrypt && (skip_eff != '0));
  assign advance = cmd_valid_i && (!emit || res_ready_i);

  assign res_valid_o    = emit && res_ready_i;
  assign res_o.out_byte = xor_byte;
  assign res_o.run_last = !in_prefix;
  assign cmd_pop_o      = advance && !in_prefix;

  always_comb begin
    key_d  = key_q;
    skip_d = skip_q;
    pend_d = pend_q;
    step_d = step_q;
    if (advance) begin
      key_d  = next_key(key_eff, ciph_byte);
      skip_d = skip_eff;
      pend_d = pend_eff;
      if (cmd_i.decrypt) begin
        if (skip_eff != '0) begin
          skip_d = skip_eff - 3'd1;
        end
        step_d = '0;
      end else if (in_prefix) begin
        step_d = step_q + 1'b1;
      end else begin
        pend_d = 1'b0;
        step_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= SEED_EEXEC;
      skip_q <= DISCARD_RESET;
      pend_q <= 1'b1;
      step_q <= '0;
    end else begin
      key_q  <= key_d;
      skip_q <= skip_d;
      pend_q <= pend_d;
      step_q <= step_d;
    end
  end

endmodule

// ===== hdl/t1ex_resq.sv =====
module t1ex_resq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  t1ex_pkg::result_t res_i,
  input  logic              res_valid_i,
  output logic              res_ready_o,
  output t1ex_pkg::result_t result_o,
  output logic              empty_o,
  input  logic              pop_i
);
  import t1ex_pkg::*;

  result_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign res_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign empty_o     = (cnt_q == '0);
  assign do_push     = res_valid_i && res_ready_o;
  assign do_pop      = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  assign result_o = mem_q[rd_ptr_q];

endmodule

// ===== hdl/type1_eexec_cipher_top.sv =====
// Channel    | Direction | Handshake          | Payload
// -----------+-----------+--------------------+--------------------------------
// input      | in        | push / full        | item_i   (data_byte, stream_start)
// result     | out       | empty / pop        | result_o (out_byte, run_last)
// config     | in/out    | APB psel .. pready | pwdata / prdata, four registers
//
// In decrypt mode the block takes one item per cycle while the result queue has room, and
// gives at most one result each. In encrypt mode an item that finds the prefix still pending
// (the first item of a stream) gives PREFIX_BYTES + 1 results, one per key update, since all
// results run through the single key update multiplier; later items wait. Others give one.
// An item is held in the input queue, and its result in the result queue, before it shows.
// Reset loads the register defaults and the eexec seed; there is no clearing pass.
// Input and result queues are two items deep, so either side may stall on its own.
module type1_eexec_cipher_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input item queue side.
  input  t1ex_pkg::item_t                 item_i,
  input  logic                            push,
  output logic                            full,
  // Result queue side.
  output t1ex_pkg::result_t               result_o,
  output logic                            empty,
  input  logic                            pop,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [t1ex_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [t1ex_pkg::APB_DATA_W-1:0] pwdata,
  output logic [t1ex_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import t1ex_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  logic    cmd_valid, cmd_pop;
  result_t res;
  logic    res_valid, res_ready;

  // Register file: mode, seed, prefix key and discard count.
  t1ex_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Front end: accepts each item, tags it with the current mode and queues it.
  t1ex_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .push_i      (push),
    .full_o      (full),
    .decrypt_i   (cfg.decrypt_mode),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // Key engine: one cipher byte and one key update per cycle, unless a full result queue holds
  // it. It walks the prefix bytes of an encrypt stream before the data byte and drops the
  // leading decrypted bytes while still advancing the key.
  t1ex_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready)
  );

  // Result queue, which holds finished items until they are popped.
  t1ex_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .result_o    (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

// ===== test/tb_type1_eexec_cipher_top.sv =====
// Testbench for type1_eexec_cipher_top.
//
// The block is driven as a pair of queues: items go in through push/full and
// result items come back through empty/pop. Settings are written over the APB
// port only while the block is idle. A behavioral model of the cipher lives in
// this module. It keeps its own copy of the running key, the decrypt drop
// counter, the prefix flag and the four settings, and at every accepted item it
// appends the result items that item must produce to a queue. Every popped result
// item is compared with the head of that queue.
//
// The run has two parts. A short table of directed items comes first. It covers
// bytes sent before any stream start, the zero and all-ones byte values, the
// seed extremes, the all-ones prefix, a drop count above four, and a change of mode in the
// middle of a stream. Where a row's answer is plain (a dropped byte, or a first
// byte decrypted under a seed whose high byte is known), the row carries that
// answer and it replaces the model's output. A series of random phases follows.
// Each phase writes fresh settings, then sends byte streams of random length and
// content in bursts with random gaps.
module tb_type1_eexec_cipher_top;
  import t1ex_pkg::*;

  localparam int          CLK_HALF       = 4;
  localparam int          TIMEOUT_CYCLES = 200_000;
  // Cycles of quiet before a settings write or the final verdict, so that a dropped
  // byte that is still in flight has retired by then.
  localparam int          SETTLE_CYCLES  = 12;
  localparam int          LONG_HOLD      = 64;
  localparam int          RANDOM_PHASES  = 10;
  localparam int          PHASE_ITEMS    = 42;
  localparam logic [15:0] KEY_MULT       = 16'd52845;
  localparam logic [15:0] KEY_INC        = 16'd22719;
  localparam logic [15:0] SEED_CHARS     = 16'd4330;

  // How a directed row checks its item.
  typedef enum logic [1:0] {
    PIN_NONE,   // the model decides
    PIN_DROP,   // no result item at all
    PIN_BYTE    // exactly one result item with the given byte, closing the run
  } pin_e;

  typedef enum logic {
    ROW_WRITE,
    ROW_ITEM
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    reg_idx_e    reg_sel;
    logic [31:0] value;
    item_t       item;
    pin_e        pin;
    logic [7:0]  pin_byte;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  item_t       item_i;
  logic        push;
  logic        full;
  result_t     result_o;
  logic        empty;
  logic        pop;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic        pready;

  // These travel alongside item_i, so the checker sees them with their item.
  pin_e        pin_kind;
  logic [7:0]  pin_byte;

  // The model's copy of the settings, reset values included.
  logic        decrypt_q    = 1'b1;
  logic [15:0] seed_q       = SEED_EEXEC;
  logic [31:0] prefix_q     = 32'h0;
  logic [2:0]  discard_q    = DISCARD_RESET;
  // The model's stream state. Bytes sent before any stream start use these values.
  logic [15:0] key_q        = SEED_EEXEC;
  logic [2:0]  skip_q       = DISCARD_RESET;
  logic        prefix_due_q = 1'b1;

  result_t     step_bytes[$];       // result items of the item just accepted
  result_t     cipher_bytes_due[$]; // result items still awaited from the block
  int          fault_count = 0;
  // The sender asks for a long receiver hold-off by raising this count.
  int          hold_requests = 0;

  type1_eexec_cipher_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .push    (push),
    .full    (full),
    .result_o(result_o),
    .empty   (empty),
    .pop     (pop),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // XOR one byte with the key's high byte and advance the key. The key moves
  // by the ciphertext byte: the input when decrypting, the output when encrypting.
  function automatic logic [7:0] key_xor_step(input logic [7:0] b, input logic decrypting);
    logic [7:0]  res;
    logic [15:0] sum16;
    logic [31:0] prod;
    res   = key_q[15:8] ^ b;
    sum16 = key_q + {8'h00, (decrypting ? b : res)};
    prod  = sum16 * KEY_MULT;
    key_q = prod[15:0] + KEY_INC;
    return res;
  endfunction

  // Fills step_bytes with the result items that one accepted item produces.
  function automatic void predict_cipher(input item_t it);
    logic [7:0] b;
    logic [7:0] pb;
    step_bytes.delete();
    if (it.stream_start) begin
      key_q        = seed_q;
      skip_q       = discard_q;
      prefix_due_q = 1'b1;
    end
    if (decrypt_q) begin
      // A dropped byte still moves the key.
      b = key_xor_step(it.data_byte, 1'b1);
      if (skip_q != 3'd0) begin
        skip_q = skip_q - 3'd1;
      end else begin
        step_bytes.push_back('{out_byte: b, run_last: 1'b1});
      end
    end else begin
      if (prefix_due_q) begin
        for (int i = int'(PREFIX_BYTES) - 1; i >= 0; i--) begin
          pb = (i < 4) ? prefix_q[8*i +: 8] : 8'h00;
          step_bytes.push_back('{out_byte: key_xor_step(pb, 1'b0), run_last: 1'b0});
        end
        prefix_due_q = 1'b0;
      end
      step_bytes.push_back('{out_byte: key_xor_step(it.data_byte, 1'b0), run_last: 1'b1});
    end
  endfunction

  // Scoreboard. The inputs change only by nonblocking assignments at the rising
  // edge, so at each edge this block sees the values that the DUT saw at that edge.
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    if (rst_ni) begin
      if (push && !full) begin
        predict_cipher(item_i);
        case (pin_kind)
          PIN_NONE: foreach (step_bytes[k]) cipher_bytes_due.push_back(step_bytes[k]);
          PIN_BYTE: cipher_bytes_due.push_back('{out_byte: pin_byte, run_last: 1'b1});
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (cipher_bytes_due.size() == 0) begin
          $error("result item with none expected: out_byte %02h run_last %0b",
                 result_o.out_byte, result_o.run_last);
          fault_count++;
        end else begin
          want = cipher_bytes_due.pop_front();
          if (result_o.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, result_o.out_byte);
            fault_count++;
          end
          if (result_o.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, result_o.run_last);
            fault_count++;
          end
        end
      end
    end
  end

  // The receiver runs in stretches of three kinds: pop every cycle, pop at
  // random, or pop in a repeating pattern. When the sender asks, it holds pop low for
  // a long stretch instead, so that both of the block's queues fill up.
  initial begin : receiver
    int style;
    int span;
    pop <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_requests != 0) begin
        hold_requests--;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        style = $urandom_range(0, 2);
        span  = $urandom_range(4, 30);
        for (int k = 0; k < span; k++) begin
          case (style)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            default: pop <= (k % 3 == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Offers one item and returns at the edge where the block accepts it. The
  // caller lowers push only if a gap follows, so that back-to-back items keep
  // push high.
  task automatic send_item(input item_t it, input pin_e pin, input logic [7:0] pb);
    item_i   <= it;
    pin_kind <= pin;
    pin_byte <= pb;
    push     <= 1'b1;
    do @(posedge clk_i); while (full);
  endtask

  // Stops sending, waits for every expected result item and lets any dropped
  // byte still inside the block retire.
  task automatic settle_block();
    push <= 1'b0;
    while (cipher_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB write: a setup cycle, then an access cycle that lasts until pready.
  task automatic apb_write(input reg_idx_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_DECRYPT_MODE:  decrypt_q = v[0];
      REG_SEED_VALUE:    seed_q    = v[15:0];
      REG_PREFIX_KEY:    prefix_q  = v;
      REG_DISCARD_COUNT: discard_q = v[2:0];
      default: ;
    endcase
  endtask

  function automatic dir_row_t cfg_row(input reg_idx_e r, input logic [31:0] v);
    return '{kind: ROW_WRITE, reg_sel: r, value: v, item: '0, pin: PIN_NONE, pin_byte: 8'h00};
  endfunction

  function automatic dir_row_t item_row(input logic [7:0] b, input logic ss,
                                        input pin_e p, input logic [7:0] pb);
    return '{kind: ROW_ITEM, reg_sel: REG_DECRYPT_MODE, value: 32'h0,
             item: '{data_byte: b, stream_start: ss}, pin: p, pin_byte: pb};
  endfunction

  // Random settings for a phase. The seed and the prefix hit their extremes and
  // the two standard seeds often. The drop count is drawn from zero to seven.
  task automatic random_settings();
    logic [15:0] seed;
    logic [31:0] pk;
    case ($urandom_range(0, 4))
      0:       seed = 16'h0000;
      1:       seed = 16'hFFFF;
      2:       seed = SEED_EEXEC;
      3:       seed = SEED_CHARS;
      default: seed = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       pk = 32'h0000_0000;
      1:       pk = 32'hFFFF_FFFF;
      default: pk = $urandom;
    endcase
    settle_block();
    apb_write(REG_DECRYPT_MODE, 32'($urandom_range(0, 1)));
    apb_write(REG_SEED_VALUE, {16'h0, seed});
    apb_write(REG_PREFIX_KEY, pk);
    apb_write(REG_DISCARD_COUNT, 32'($urandom_range(0, 7)));
  endtask

  // One random phase of byte streams. About one item in ten opens a new stream.
  // The first item of a phase continues the old stream half the time, so that
  // new settings, a mode change among them, also take effect in mid-stream.
  task automatic random_phase(input bit long_hold, input bit full_pause);
    item_t it;
    int    sent;
    int    burst;
    int    gap;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
        it.data_byte    = 8'($urandom);
        it.stream_start = (sent == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
        send_item(it, PIN_NONE, 8'h00);
        sent++;
        if (long_hold && sent == 2) hold_requests++;
        if (full_pause && sent == PHASE_ITEMS / 2) begin
          // Sender stops until the block has given back everything owed.
          push <= 1'b0;
          do @(posedge clk_i); while (cipher_bytes_due.size() != 0);
        end
      end
      // Some bursts run straight into the next one.
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin : stimulus
    dir_row_t directed_rows[$];
    item_i   <= '0;
    push     <= 1'b0;
    pin_kind <= PIN_NONE;
    pin_byte <= 8'h00;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;

    directed_rows = '{
      // Reset settings: decrypt, eexec seed, drop four. Bytes before any
      // stream start use the reset state, so the first four are dropped.
      item_row(8'h00, 1'b0, PIN_DROP, 8'h00),
      item_row(8'hFF, 1'b0, PIN_DROP, 8'h00),
      item_row(8'h5A, 1'b0, PIN_DROP, 8'h00),
      item_row(8'hA5, 1'b0, PIN_DROP, 8'h00),
      item_row(8'h00, 1'b0, PIN_NONE, 8'h00),
      item_row(8'hFF, 1'b1, PIN_DROP, 8'h00),
      // With a zero seed and no drops, the first byte passes through unchanged.
      cfg_row(REG_DISCARD_COUNT, 32'd0),
      cfg_row(REG_SEED_VALUE, 32'h0000),
      item_row(8'hAB, 1'b1, PIN_BYTE, 8'hAB),
      item_row(8'h3C, 1'b0, PIN_NONE, 8'h00),
      // An all-ones seed inverts the first byte.
      cfg_row(REG_SEED_VALUE, 32'hFFFF),
      item_row(8'h00, 1'b1, PIN_BYTE, 8'hFF),
      item_row(8'hFF, 1'b0, PIN_NONE, 8'h00),
      // A drop count above four drops every byte of this short stream.
      cfg_row(REG_DISCARD_COUNT, 32'd7),
      item_row(8'h12, 1'b1, PIN_DROP, 8'h00),
      item_row(8'h34, 1'b0, PIN_DROP, 8'h00),
      item_row(8'h56, 1'b0, PIN_DROP, 8'h00),
      item_row(8'h78, 1'b0, PIN_DROP, 8'h00),
      // Encrypt: the all-ones prefix goes out ahead of the first data byte.
      cfg_row(REG_DECRYPT_MODE, 32'd0),
      cfg_row(REG_PREFIX_KEY, 32'hFFFF_FFFF),
      cfg_row(REG_SEED_VALUE, 32'h0000),
      item_row(8'h00, 1'b1, PIN_NONE, 8'h00),
      item_row(8'hFF, 1'b0, PIN_NONE, 8'h00),
      // Switch to decrypt in mid-stream. The encrypt stream start loaded a drop
      // count of seven, so the next bytes are dropped while the key runs on.
      cfg_row(REG_DECRYPT_MODE, 32'd1),
      item_row(8'h80, 1'b0, PIN_DROP, 8'h00),
      item_row(8'h01, 1'b0, PIN_DROP, 8'h00),
      // Back to encrypt: the prefix was already sent, so only the data byte is.
      cfg_row(REG_DECRYPT_MODE, 32'd0),
      item_row(8'h7F, 1'b0, PIN_NONE, 8'h00),
      // Charstring seed with a mixed prefix.
      cfg_row(REG_SEED_VALUE, {16'h0, SEED_CHARS}),
      cfg_row(REG_PREFIX_KEY, 32'h0123_4567),
      cfg_row(REG_DISCARD_COUNT, 32'd0),
      item_row(8'h55, 1'b1, PIN_NONE, 8'h00),
      item_row(8'hAA, 1'b0, PIN_NONE, 8'h00),
      // Decrypt in mid-stream with the counter that the last start loaded (zero).
      cfg_row(REG_DECRYPT_MODE, 32'd1),
      item_row(8'hC3, 1'b0, PIN_NONE, 8'h00)
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        settle_block();
        apb_write(directed_rows[r].reg_sel, directed_rows[r].value);
      end else begin
        send_item(directed_rows[r].item, directed_rows[r].pin, directed_rows[r].pin_byte);
      end
    end

    // Phase 2 asks for the long receiver hold-off. Phase 5 pauses the sender
    // until the block has returned every result item it owes.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_settings();
      random_phase(p == 2, p == 5);
    end

    push <= 1'b0;
    while (cipher_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("type1_eexec_cipher_top verification clean");
    end else begin
      $display("type1_eexec_cipher_top verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("type1_eexec_cipher_top verification failed");
    $finish;
  end

endmodule
